/* rtl/ppc_pkg.sv */
package ppc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned SIDE_W     = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_MIN     = 3'd0,
    REG_HEIGHT_MAX     = 3'd1,
    REG_FORWARD_MIN    = 3'd2,
    REG_SIDE_MIN       = 3'd3,
    REG_NEAR_RADIUS_SQ = 3'd4
  } cfg_reg_e;

  localparam logic signed [15:0]       HEIGHT_MIN_RST     = 16'sd75;
  localparam logic signed [15:0]       HEIGHT_MAX_RST     = 16'sd500;
  localparam logic signed [15:0]       FORWARD_MIN_RST    = 16'sd250;
  localparam logic [SIDE_W-1:0]        SIDE_MIN_RST       = 15'd300;
  localparam logic [DIST_W-1:0]        NEAR_RADIUS_SQ_RST = 32'd902500;

  typedef struct packed {
    logic signed [15:0]  height_min;
    logic signed [15:0]  height_max;
    logic signed [15:0]  forward_min;
    logic [SIDE_W-1:0]   side_min;
    logic [DIST_W-1:0]   near_radius_sq;
  } cfg_t;

endpackage

/* rtl/ppc_front.sv */
module ppc_front #(
  parameter int unsigned COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic signed [COORD_BITS-1:0]  point_z_i,
  input  logic                          is_last_i,
  input  ppc_pkg::cfg_t                 cfg_i,
  output logic                          push_o,
  output logic [2*COORD_BITS+ppc_pkg::HEIGHT_W+1:0] push_data_o,
  input  logic                          full_i
);

  localparam int unsigned CW = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int unsigned SW = (COORD_BITS > ppc_pkg::SIDE_W) ? COORD_BITS : ppc_pkg::SIDE_W;

  logic signed [CW-1:0]          x_ext;
  logic signed [CW-1:0]          z_ext;
  logic signed [CW-1:0]          hmin_ext;
  logic signed [CW-1:0]          hmax_ext;
  logic signed [CW-1:0]          fmin_ext;
  logic [COORD_BITS-1:0]         ax;
  logic [COORD_BITS-1:0]         ay;
  logic                          close_pt;
  logic                          counts;
  logic [ppc_pkg::HEIGHT_W-1:0]  z16;

  assign x_ext    = CW'(point_x_i);
  assign z_ext    = CW'(point_z_i);
  assign hmin_ext = CW'(cfg_i.height_min);
  assign hmax_ext = CW'(cfg_i.height_max);
  assign fmin_ext = CW'(cfg_i.forward_min);

  assign ax = point_x_i[COORD_BITS-1] ? COORD_BITS'(~$unsigned(point_x_i) + 1'b1)
                                      : $unsigned(point_x_i);
  assign ay = point_y_i[COORD_BITS-1] ? COORD_BITS'(~$unsigned(point_y_i) + 1'b1)
                                      : $unsigned(point_y_i);

  assign close_pt = (SW'(ay) < SW'(cfg_i.side_min)) && (x_ext < fmin_ext);
  assign counts   = (z_ext > hmin_ext) && (z_ext < hmax_ext) && (x_ext > fmin_ext) && !close_pt;
  assign z16      = z_ext[ppc_pkg::HEIGHT_W-1:0];

  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i;
  assign push_data_o = {counts, ax, ay, z16, is_last_i};

endmodule

/* rtl/ppc_queue.sv */
module ppc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_i
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/ppc_back.sv */
module ppc_back #(
  parameter int unsigned COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      pop_valid_i,
  input  logic [2*COORD_BITS+ppc_pkg::HEIGHT_W+1:0] pop_data_i,
  output logic                                      pop_o,
  input  logic [ppc_pkg::DIST_W-1:0]                near_radius_sq_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      is_obstacle_o,
  output logic                                      proximity_o,
  output logic [ppc_pkg::DIST_W-1:0]                min_dist_sq_o,
  output logic signed [ppc_pkg::HEIGHT_W-1:0]       height_at_min_o,
  output logic                                      cloud_done_o
);

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned KW = (PW > ppc_pkg::DIST_W) ? PW : ppc_pkg::DIST_W;

  logic                          q_counts;
  logic [COORD_BITS-1:0]         q_ax;
  logic [COORD_BITS-1:0]         q_ay;
  logic [ppc_pkg::HEIGHT_W-1:0]  q_z;
  logic                          q_last;

  logic                          en;

  logic                          a_valid_q;
  logic                          a_counts_q;
  logic [PW-1:0]                 a_sqx_q;
  logic [PW-1:0]                 a_sqy_q;
  logic [ppc_pkg::HEIGHT_W-1:0]  a_z_q;
  logic                          a_last_q;

  logic [PW-1:0]                 sum_sq;
  logic                          near;
  logic                          better;

  logic                          any_near_q;
  logic [ppc_pkg::DIST_W-1:0]    best_dist_q;
  logic [ppc_pkg::HEIGHT_W-1:0]  best_height_q;
  logic                          any_near_d;
  logic [ppc_pkg::DIST_W-1:0]    best_dist_d;
  logic [ppc_pkg::HEIGHT_W-1:0]  best_height_d;

  logic                          out_valid_q;
  logic                          obst_q;
  logic                          prox_q;
  logic [ppc_pkg::DIST_W-1:0]    min_dist_q;
  logic [ppc_pkg::HEIGHT_W-1:0]  height_q;
  logic                          done_q;

  assign {q_counts, q_ax, q_ay, q_z, q_last} = pop_data_i;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = pop_valid_i && en;

  assign sum_sq = PW'(a_sqx_q + a_sqy_q);
  assign near   = a_counts_q && (KW'(sum_sq) < KW'(near_radius_sq_i));
  assign better = near && (KW'(best_dist_q) > KW'(sum_sq));

  always_comb begin
    any_near_d    = any_near_q || near;
    best_dist_d   = better ? ppc_pkg::DIST_W'(sum_sq) : best_dist_q;
    best_height_d = better ? a_z_q : best_height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      any_near_q    <= 1'b0;
      best_dist_q   <= '1;
      best_height_q <= '0;
    end else if (en) begin
      a_valid_q   <= pop_valid_i;
      out_valid_q <= a_valid_q;
      if (a_valid_q) begin
        if (a_last_q) begin
          any_near_q    <= 1'b0;
          best_dist_q   <= '1;
          best_height_q <= '0;
        end else begin
          any_near_q    <= any_near_d;
          best_dist_q   <= best_dist_d;
          best_height_q <= best_height_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_counts_q <= q_counts;
      a_sqx_q    <= PW'(q_ax) * PW'(q_ax);
      a_sqy_q    <= PW'(q_ay) * PW'(q_ay);
      a_z_q      <= q_z;
      a_last_q   <= q_last;
      obst_q     <= near;
      prox_q     <= any_near_d;
      min_dist_q <= best_dist_d;
      height_q   <= best_height_d;
      done_q     <= a_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_obstacle_o   = obst_q;
  assign proximity_o     = prox_q;
  assign min_dist_sq_o   = min_dist_q;
  assign height_at_min_o = $signed(height_q);
  assign cloud_done_o    = done_q;

endmodule

/* rtl/point_proximity_checker_top.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    point_x, point_y, point_z, is_last
// out      output     out_valid/out_stall  is_obstacle, proximity, min_dist_sq,
//                                          height_at_min, cloud_done
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One point per cycle while the output is not stalled; a point passes the queue entry,
// the squaring stage, then the compare and minimum update into the output register.
// A two-entry queue splits the classifier from the squaring and update pipe.
// Reset is asynchronous, active low; only control, state and config registers reset.
// A stalled output holds the back pipe; input stalls only when the queue is full.
module point_proximity_checker_top #(
  parameter int unsigned COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          point_x_i,
  input  logic signed [COORD_BITS-1:0]          point_y_i,
  input  logic signed [COORD_BITS-1:0]          point_z_i,
  input  logic                                  is_last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  is_obstacle_o,
  output logic                                  proximity_o,
  output logic [ppc_pkg::DIST_W-1:0]            min_dist_sq_o,
  output logic signed [ppc_pkg::HEIGHT_W-1:0]   height_at_min_o,
  output logic                                  cloud_done_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned QW = 2 * COORD_BITS + ppc_pkg::HEIGHT_W + 2;

  ppc_pkg::cfg_t   cfg_q;
  logic            push;
  logic [QW-1:0]   push_data;
  logic            full;
  logic            pop_valid;
  logic [QW-1:0]   pop_data;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height_min     <= ppc_pkg::HEIGHT_MIN_RST;
      cfg_q.height_max     <= ppc_pkg::HEIGHT_MAX_RST;
      cfg_q.forward_min    <= ppc_pkg::FORWARD_MIN_RST;
      cfg_q.side_min       <= ppc_pkg::SIDE_MIN_RST;
      cfg_q.near_radius_sq <= ppc_pkg::NEAR_RADIUS_SQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ppc_pkg::REG_HEIGHT_MIN:     cfg_q.height_min     <= $signed(cfg_data_i[15:0]);
        ppc_pkg::REG_HEIGHT_MAX:     cfg_q.height_max     <= $signed(cfg_data_i[15:0]);
        ppc_pkg::REG_FORWARD_MIN:    cfg_q.forward_min    <= $signed(cfg_data_i[15:0]);
        ppc_pkg::REG_SIDE_MIN:       cfg_q.side_min       <= cfg_data_i[ppc_pkg::SIDE_W-1:0];
        ppc_pkg::REG_NEAR_RADIUS_SQ: cfg_q.near_radius_sq <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ppc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .is_last_i   (is_last_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ppc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_i       (pop)
  );

  ppc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .near_radius_sq_i (cfg_q.near_radius_sq),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_obstacle_o    (is_obstacle_o),
    .proximity_o      (proximity_o),
    .min_dist_sq_o    (min_dist_sq_o),
    .height_at_min_o  (height_at_min_o),
    .cloud_done_o     (cloud_done_o)
  );

endmodule

/* rtl/ppc_checker.sv */
module ppc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                is_obstacle_o,
  input logic                                proximity_o,
  input logic [ppc_pkg::DIST_W-1:0]          min_dist_sq_o,
  input logic signed [ppc_pkg::HEIGHT_W-1:0] height_at_min_o,
  input logic                                cloud_done_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_dist_sq_o)
      && $stable(proximity_o) && $stable(cloud_done_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_obstacle_o |-> proximity_o && (min_dist_sq_o != '1))
    else $error("obstacle without proximity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !proximity_o |-> (min_dist_sq_o == '1) && (height_at_min_o == '0))
    else $error("minimum set without near point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && proximity_o |-> (min_dist_sq_o != '1))
    else $error("proximity without minimum");

endmodule

bind point_proximity_checker_top ppc_checker u_ppc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .is_obstacle_o   (is_obstacle_o),
  .proximity_o     (proximity_o),
  .min_dist_sq_o   (min_dist_sq_o),
  .height_at_min_o (height_at_min_o),
  .cloud_done_o    (cloud_done_o)
);
